FILE: design/gtrc_pkg.sv
// Shared types and constants for the generation-tagged result cache.
// No dependencies; gtrc_hash and the cache core refer to it by scoped names.
`default_nettype none

package gtrc_pkg;

    // Request codes
    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_STORE  = 2'd1;
    localparam logic [1:0] REQ_INVAL  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_FUNC_A = 2'd0;
    localparam logic [1:0] CFG_FUNC_B = 2'd1;
    localparam logic [1:0] CFG_FUNC_C = 2'd2;
    localparam logic [1:0] CFG_FUNC_D = 2'd3;

    localparam logic [31:0] FUNC_A_RST = 32'h0060_EB60;
    localparam logic [31:0] FUNC_B_RST = 32'h0060_ED40;
    localparam logic [31:0] FUNC_C_RST = 32'h0060_FEC0;
    localparam logic [31:0] FUNC_D_RST = 32'h0000_0000;

    // FNV-1a 32-bit
    localparam logic [31:0] FNV_BASIS  = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME  = 32'd16777619;
    localparam int          ADDR_LOW_W = 12;

    localparam logic [31:0] GEN_RST = 32'd1;

    // One table line
    typedef struct packed {
        logic [31:0] key;
        logic [31:0] func;
        logic [63:0] value;
        logic [31:0] gen;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Request as it travels down the pipeline
    typedef struct packed {
        logic [1:0]  req;
        logic        allowed;
        logic [31:0] func;
        logic [31:0] arg;
        logic [63:0] value;
    } t_item;

endpackage

`default_nettype wire

FILE: design/gtrc_req_if.sv
// Request channel: valid/ready handshake plus the request word.
// No dependencies.
`default_nettype none

interface gtrc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] func_addr;
    logic [31:0] arg_hash;
    logic [63:0] store_value;

    modport source(output valid, output req_type, output func_addr, output arg_hash,
                   output store_value, input ready);
    modport sink(input valid, input req_type, input func_addr, input arg_hash,
                 input store_value, output ready);
endinterface

`default_nettype wire

FILE: design/gtrc_rsp_if.sv
// Result channel: valid/ready handshake plus hit flag and cached word.
// No dependencies.
`default_nettype none

interface gtrc_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [63:0] cached_value;

    modport source(output valid, output hit, output cached_value, input ready);
    modport sink(input valid, input hit, input cached_value, output ready);
endinterface

`default_nettype wire

FILE: design/gtrc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gtrc_ram #(
    parameter int WIDTH = 160,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: design/gtrc_hash.sv
// Two-stage FNV-1a key pipeline: one registered multiply per round.
// Depends on gtrc_pkg.
`default_nettype none

module gtrc_hash (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire gtrc_pkg::t_item i_item,
    output logic                o_valid,
    output gtrc_pkg::t_item     o_item,
    output logic [31:0]         o_key
);

    logic            r_s1_valid;
    gtrc_pkg::t_item r_s1_item;
    logic [31:0]     r_h1;
    logic            r_s2_valid;
    gtrc_pkg::t_item r_s2_item;
    logic [31:0]     r_key;

    logic [31:0] w_seed;
    logic [31:0] w_h1;
    logic [31:0] w_mix;
    logic [31:0] w_key;

    // Round one only needs the low address bits
    assign w_seed = gtrc_pkg::FNV_BASIS
                  ^ {{(32-gtrc_pkg::ADDR_LOW_W){1'b0}},
                     i_item.func[gtrc_pkg::ADDR_LOW_W-1:0]};
    assign w_h1   = w_seed * gtrc_pkg::FNV_PRIME;
    assign w_mix  = r_h1 ^ r_s1_item.arg;
    assign w_key  = w_mix * gtrc_pkg::FNV_PRIME;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_item <= i_item;
            r_h1      <= w_h1;
            r_s2_item <= r_s1_item;
            r_key     <= w_key;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_item  = r_s2_item;
    assign o_key   = r_key;

endmodule

`default_nettype wire

FILE: design/generation_tagged_result_cache_core.sv
// Direct-mapped memo cache of 64-bit results, tagged by key, function address and a
// generation count. A request is accepted each cycle the result side is not stalled;
// its result word passes four register stages (two registered hash multiplies, one
// table read, one output register), so the block sustains one request per cycle
// while the result side is not stalled.
// After reset the table is cleared one line per cycle, during which no request is
// taken; configuration writes are taken at any time. ENTRIES must be a power of two:
// the table index is the low bits of the key.
// Depends on gtrc_pkg, gtrc_req_if, gtrc_rsp_if, gtrc_ram and gtrc_hash.
`default_nettype none

module generation_tagged_result_cache_core #(
    parameter int ENTRIES = 256
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    gtrc_req_if.sink    i_req,
    gtrc_rsp_if.source  o_rsp
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    logic [31:0] r_func_a, r_func_b, r_func_c, r_func_d;
    logic [31:0] r_gen;
    logic        r_clearing;
    logic [IDX_W-1:0] r_clr_idx;

    logic             w_en;
    logic             w_in_valid;
    gtrc_pkg::t_item  w_in_item;

    logic             w_s2_valid;
    gtrc_pkg::t_item  w_s2_item;
    logic [31:0]      w_s2_key;
    logic [IDX_W-1:0] w_s2_idx;

    logic             r_s3_valid;
    logic [1:0]       r_s3_req;
    logic             r_s3_allowed;
    logic [31:0]      r_s3_func;
    logic [31:0]      r_s3_key;

    logic             w_wr_en;
    logic [IDX_W-1:0] w_wr_addr;
    gtrc_pkg::t_entry w_wr_entry;
    gtrc_pkg::t_entry w_store_entry;
    logic             w_rd_en;
    gtrc_pkg::t_entry w_rd_entry;
    logic             w_hit;

    logic        r_out_valid;
    logic        r_out_hit;
    logic [63:0] r_out_value;

    // Whole pipeline moves together whenever the output register can take a word
    assign w_en        = !r_out_valid || o_rsp.ready;
    assign i_req.ready = w_en && !r_clearing;
    assign w_in_valid  = i_req.valid && i_req.ready;

    assign w_in_item.req     = i_req.req_type;
    assign w_in_item.allowed = (i_req.func_addr == r_func_a) || (i_req.func_addr == r_func_b)
                            || (i_req.func_addr == r_func_c) || (i_req.func_addr == r_func_d);
    assign w_in_item.func    = i_req.func_addr;
    assign w_in_item.arg     = i_req.arg_hash;
    assign w_in_item.value   = i_req.store_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_func_a <= gtrc_pkg::FUNC_A_RST;
            r_func_b <= gtrc_pkg::FUNC_B_RST;
            r_func_c <= gtrc_pkg::FUNC_C_RST;
            r_func_d <= gtrc_pkg::FUNC_D_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gtrc_pkg::CFG_FUNC_A: r_func_a <= i_cfg_data;
                gtrc_pkg::CFG_FUNC_B: r_func_b <= i_cfg_data;
                gtrc_pkg::CFG_FUNC_C: r_func_c <= i_cfg_data;
                gtrc_pkg::CFG_FUNC_D: r_func_d <= i_cfg_data;
                default: ;
            endcase
        end
    end

    gtrc_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_in_valid),
        .i_item  (w_in_item),
        .o_valid (w_s2_valid),
        .o_item  (w_s2_item),
        .o_key   (w_s2_key)
    );

    assign w_s2_idx = w_s2_key[IDX_W-1:0];

    // Stores write as they leave the key stage; lookups read there. One item per
    // stage keeps table accesses in request order, so no forwarding is needed.
    assign w_store_entry.key   = w_s2_key;
    assign w_store_entry.func  = w_s2_item.func;
    assign w_store_entry.value = w_s2_item.value;
    assign w_store_entry.gen   = r_gen;

    assign w_wr_en    = r_clearing || (w_en && w_s2_valid && w_s2_item.allowed
                                       && (w_s2_item.req == gtrc_pkg::REQ_STORE));
    assign w_wr_addr  = r_clearing ? r_clr_idx : w_s2_idx;
    assign w_wr_entry = r_clearing ? '0 : w_store_entry;
    assign w_rd_en    = w_en && w_s2_valid && (w_s2_item.req == gtrc_pkg::REQ_LOOKUP);

    gtrc_ram #(
        .WIDTH (gtrc_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_entry),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_s2_idx),
        .o_rd_data (w_rd_entry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == LAST_IDX) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Generation steps when an invalidate leaves the key stage; zero is skipped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen <= gtrc_pkg::GEN_RST;
        end else if (w_en && w_s2_valid && (w_s2_item.req == gtrc_pkg::REQ_INVAL)) begin
            r_gen <= (r_gen == '1) ? gtrc_pkg::GEN_RST : r_gen + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_en) begin
            r_s3_valid <= w_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_req     <= w_s2_item.req;
            r_s3_allowed <= w_s2_item.allowed;
            r_s3_func    <= w_s2_item.func;
            r_s3_key     <= w_s2_key;
        end
    end

    // r_gen already holds every earlier invalidate and none of the later ones here
    assign w_hit = (r_s3_req == gtrc_pkg::REQ_LOOKUP) && r_s3_allowed
                && (w_rd_entry.key == r_s3_key) && (w_rd_entry.func == r_s3_func)
                && (w_rd_entry.gen == r_gen);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_hit   <= w_hit;
            r_out_value <= w_hit ? w_rd_entry.value : 64'd0;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.hit          = r_out_hit;
    assign o_rsp.cached_value = r_out_value;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for generation_tagged_result_cache_core: a scoreboard class
// mirrors the cache and checks each result word. Uses gtrc_pkg, gtrc_req_if, gtrc_rsp_if.

module testbench;

    localparam int         LINES    = 256;
    localparam int         LATENCY  = 4;
    localparam logic [1:0] REQ_NOP  = 2'd3;   // unused code, block answers with a miss
    localparam int         PHASE_SZ = 400;

    class cache_scoreboard;
        typedef struct {
            logic        hit;
            logic [63:0] value;
        } t_answer;

        logic [31:0]      whitelist [4];
        gtrc_pkg::t_entry lines [LINES];
        logic [31:0]      generation;
        t_answer          awaited_rsp [$];
        int               errors;
        int               n_requests;
        int               n_hits;
        int               n_invals;

        function new();
            whitelist[gtrc_pkg::CFG_FUNC_A] = gtrc_pkg::FUNC_A_RST;
            whitelist[gtrc_pkg::CFG_FUNC_B] = gtrc_pkg::FUNC_B_RST;
            whitelist[gtrc_pkg::CFG_FUNC_C] = gtrc_pkg::FUNC_C_RST;
            whitelist[gtrc_pkg::CFG_FUNC_D] = gtrc_pkg::FUNC_D_RST;
            foreach (lines[i]) lines[i] = '0;
            generation = 32'd1;
            errors     = 0;
            n_requests = 0;
            n_hits     = 0;
            n_invals   = 0;
        endfunction

        function void set_whitelist(logic [1:0] idx, logic [31:0] addr);
            whitelist[idx] = addr;
        endfunction

        function bit listed(logic [31:0] addr);
            return addr == whitelist[0] || addr == whitelist[1] ||
                   addr == whitelist[2] || addr == whitelist[3];
        endfunction

        // two FNV-1a rounds: address low 12 bits, then the argument hash
        function logic [31:0] memo_key(logic [31:0] addr, logic [31:0] arg);
            logic [31:0] h;
            h = 32'd2166136261 ^ {20'd0, addr[11:0]};
            h = h * 32'd16777619;
            h = h ^ arg;
            h = h * 32'd16777619;
            return h;
        endfunction

        function void note_request(logic [1:0] kind, logic [31:0] addr, logic [31:0] arg,
                                   logic [63:0] value);
            t_answer     ans;
            logic [31:0] key;
            int          slot;
            ans.hit   = 1'b0;
            ans.value = '0;
            key  = memo_key(addr, arg);
            slot = key % LINES;
            n_requests++;
            case (kind)
                gtrc_pkg::REQ_LOOKUP: begin
                    if (listed(addr) && lines[slot].key == key && lines[slot].func == addr &&
                        lines[slot].gen == generation) begin
                        ans.hit   = 1'b1;
                        ans.value = lines[slot].value;
                        n_hits++;
                    end
                end
                gtrc_pkg::REQ_STORE: begin
                    if (listed(addr)) begin
                        lines[slot].key   = key;
                        lines[slot].func  = addr;
                        lines[slot].value = value;
                        lines[slot].gen   = generation;
                    end
                end
                gtrc_pkg::REQ_INVAL: begin
                    generation = generation + 32'd1;
                    if (generation == '0) generation = 32'd1;
                    n_invals++;
                end
                default: ;
            endcase
            awaited_rsp.push_back(ans);
        endfunction

        function void check_result(logic hit, logic [63:0] value);
            t_answer ans;
            if (awaited_rsp.size() == 0) begin
                errors++;
                $display("%t unexpected result word: hit=%0b value=%h", $time, hit, value);
                return;
            end
            ans = awaited_rsp.pop_front();
            if (hit !== ans.hit) begin
                errors++;
                $display("%t hit mismatch: expected %0b, got %0b", $time, ans.hit, hit);
            end
            if (value !== ans.value) begin
                errors++;
                $display("%t cached_value mismatch: expected %h, got %h",
                         $time, ans.value, value);
            end
        endfunction

        function int pending();
            return awaited_rsp.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    gtrc_req_if req_ch ();
    gtrc_rsp_if rsp_ch ();

    generation_tagged_result_cache_core #(
        .ENTRIES (LINES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    cache_scoreboard sb = new();
    int              tx_idle_pct = 14;
    int              rx_idle_pct = 54;
    int              n_settings  = 1;
    logic [31:0]     arg_pool [16];

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready)
                sb.note_request(req_ch.req_type, req_ch.func_addr, req_ch.arg_hash,
                                req_ch.store_value);
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_result(rsp_ch.hit, rsp_ch.cached_value);
        end
    end

    task automatic send_request(input logic [1:0] kind, input logic [31:0] addr,
                                input logic [31:0] arg, input logic [63:0] value);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= kind;
        req_ch.func_addr   <= addr;
        req_ch.arg_hash    <= arg;
        req_ch.store_value <= value;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    // hold the sender off until every result word is back
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_whitelist(idx, data);
    endtask

    task automatic program_whitelist(input logic [31:0] a, input logic [31:0] b,
                                     input logic [31:0] c, input logic [31:0] d);
        write_reg(gtrc_pkg::CFG_FUNC_A, a);
        write_reg(gtrc_pkg::CFG_FUNC_B, b);
        write_reg(gtrc_pkg::CFG_FUNC_C, c);
        write_reg(gtrc_pkg::CFG_FUNC_D, d);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        n_settings++;
    endtask

    task automatic run_random(input int count);
        int          roll;
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [31:0] arg;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(99);
            if (roll < 50)      kind = gtrc_pkg::REQ_LOOKUP;
            else if (roll < 91) kind = gtrc_pkg::REQ_STORE;
            else if (roll < 96) kind = gtrc_pkg::REQ_INVAL;
            else                kind = REQ_NOP;
            roll = $urandom_range(99);
            if (roll < 85)      addr = sb.whitelist[$urandom_range(3)];
            else if (roll < 92) addr = sb.whitelist[$urandom_range(3)] ^
                                       (32'd1 << $urandom_range(31));
            else                addr = $urandom;
            arg = ($urandom_range(99) < 85) ? arg_pool[$urandom_range(15)] : $urandom;
            send_request(kind, addr, arg, {$urandom, $urandom});
            if (i % 150 == 149) drain();
        end
    endtask

    task automatic run_directed();
        logic [31:0] fa;
        logic [31:0] fb;
        logic [31:0] fc;
        fa = gtrc_pkg::FUNC_A_RST;
        fb = gtrc_pkg::FUNC_B_RST;
        fc = gtrc_pkg::FUNC_C_RST;
        // empty table, including the zero address listed through the last register
        send_request(gtrc_pkg::REQ_LOOKUP, fa, 32'd0, '0);
        send_request(gtrc_pkg::REQ_LOOKUP, 32'd0, 32'd0, '0);
        send_request(gtrc_pkg::REQ_STORE, fa, 32'd0, '1);
        send_request(gtrc_pkg::REQ_LOOKUP, fa, 32'd0, '0);
        send_request(gtrc_pkg::REQ_STORE, fb, '1, '0);
        send_request(gtrc_pkg::REQ_LOOKUP, fb, '1, '1);
        send_request(gtrc_pkg::REQ_STORE, fc, 32'h1234_5678, 64'h8000_0000_0000_0001);
        send_request(gtrc_pkg::REQ_LOOKUP, fc, 32'h1234_5678, '0);
        // address off the list: store dropped, lookup misses
        send_request(gtrc_pkg::REQ_STORE, '1, 32'd0, 64'd5);
        send_request(gtrc_pkg::REQ_LOOKUP, '1, 32'd0, '0);
        send_request(gtrc_pkg::REQ_LOOKUP, fa, 32'd1, '0);
        send_request(gtrc_pkg::REQ_STORE, 32'd0, 32'hA5A5_A5A5, 64'h5A5A_0F0F_F0F0_A5A5);
        send_request(gtrc_pkg::REQ_LOOKUP, 32'd0, 32'hA5A5_A5A5, '0);
        send_request(REQ_NOP, '1, '1, '1);
        send_request(gtrc_pkg::REQ_LOOKUP, fa, 32'd0, '0);
        // new generation hides everything written so far
        send_request(gtrc_pkg::REQ_INVAL, 32'd0, 32'd0, '0);
        send_request(gtrc_pkg::REQ_LOOKUP, fa, 32'd0, '0);
        send_request(gtrc_pkg::REQ_LOOKUP, 32'd0, 32'hA5A5_A5A5, '0);
        send_request(gtrc_pkg::REQ_STORE, fa, 32'd0, 64'h0123_4567_89AB_CDEF);
        send_request(gtrc_pkg::REQ_LOOKUP, fa, 32'd0, '0);
        send_request(gtrc_pkg::REQ_INVAL, '1, '1, '1);
        send_request(gtrc_pkg::REQ_LOOKUP, fa, 32'd0, '0);
    endtask

    initial begin
        logic [31:0] same;
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= gtrc_pkg::CFG_FUNC_A;
        i_cfg_data         <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= gtrc_pkg::REQ_LOOKUP;
        req_ch.func_addr   <= '0;
        req_ch.arg_hash    <= '0;
        req_ch.store_value <= '0;
        arg_pool[0] = '0;
        arg_pool[1] = '1;
        for (int i = 2; i < 16; i++) arg_pool[i] = $urandom;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        drain();

        program_whitelist('1, '0, $urandom, 32'h0000_0FFF);
        run_random(PHASE_SZ);
        drain();

        tx_idle_pct = 54;
        rx_idle_pct = 14;
        program_whitelist($urandom, $urandom, $urandom, $urandom);
        run_random(PHASE_SZ);
        drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        same = $urandom;
        program_whitelist(same, same, same, same);
        run_random(PHASE_SZ);
        drain();

        program_whitelist(gtrc_pkg::FUNC_A_RST, gtrc_pkg::FUNC_B_RST, gtrc_pkg::FUNC_C_RST,
                          32'hFFFF_F000);
        run_random(PHASE_SZ);
        drain();

        if (sb.pending() != 0) begin
            sb.errors++;
            $display("%t %0d result words never arrived", $time, sb.pending());
        end
        $display("covered %0d requests: %0d hits, %0d invalidates, %0d whitelist settings",
                 sb.n_requests, sb.n_hits, sb.n_invals, n_settings);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
